@@ rtl/core/kfci_pkg.sv @@
// ============================================================================
// kfci_pkg: shared codes and types of the keyframe curve interpolator
// Mode and status codes, field widths, and the request/response bundles of
// the multiply-divide unit.
// ============================================================================
package kfci_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned INDEX_W  = 6;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned MARGIN_W = 16;
    localparam int unsigned QUO_W    = 35;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EVAL   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_HELD  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd3;

    typedef struct packed {
        logic              start;
        logic [32:0]       mul_a;
        logic [32:0]       mul_b;
        logic [32:0]       den;
    } arith_req_t;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quo;
    } arith_rsp_t;

endpackage

@@ rtl/core/kfci_in_if.sv @@
// ============================================================================
// kfci_in_if: request channel
// Valid/ready channel that carries one request of the interpolator.
// ============================================================================
interface kfci_in_if;
    logic                                valid;
    logic                                ready;
    logic [kfci_pkg::MODE_W-1:0]         mode;
    logic signed [kfci_pkg::DATA_W-1:0]  key_time;
    logic signed [kfci_pkg::DATA_W-1:0]  key_value;
    logic [kfci_pkg::INDEX_W-1:0]        key_index;
    logic signed [kfci_pkg::DATA_W-1:0]  query_time;

    modport source (output valid, mode, key_time, key_value, key_index, query_time,
                    input ready);
    modport sink (input valid, mode, key_time, key_value, key_index, query_time,
                  output ready);
endinterface

@@ rtl/core/kfci_out_if.sv @@
// ============================================================================
// kfci_out_if: response channel
// Valid/ready channel that carries one response of the interpolator.
// ============================================================================
interface kfci_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [kfci_pkg::DATA_W-1:0]  curve_value;
    logic [kfci_pkg::STATUS_W-1:0]       status;
    logic [kfci_pkg::COUNT_W-1:0]        key_count;

    modport source (output valid, curve_value, status, key_count, input ready);
    modport sink (input valid, curve_value, status, key_count, output ready);
endinterface

@@ rtl/core/kfci_muldiv.sv @@
// ============================================================================
// kfci_muldiv: sequential unsigned multiply then divide
// Forms a 33x33 product from four 17x17 partial products, then divides it by
// a 33-bit divisor one quotient bit per cycle; quotient clamped to 2^34.
// ============================================================================
module kfci_muldiv
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  kfci_pkg::arith_req_t req,
    output kfci_pkg::arith_rsp_t rsp
);

    localparam int unsigned PROD_W = 66;

    typedef enum logic [1:0] {PH_IDLE, PH_MUL, PH_DIV} phase_t;

    phase_t                       phase_reg;
    logic [1:0]                   step_reg;
    logic [6:0]                   bit_reg;
    logic [33:0]                  a_reg;
    logic [33:0]                  b_reg;
    logic [32:0]                  den_reg;
    logic [PROD_W-1:0]            acc_reg;
    logic [32:0]                  rem_reg;
    logic                         done_reg;
    logic [kfci_pkg::QUO_W-1:0]   quo_reg;

    logic [16:0]                  pa;
    logic [16:0]                  pb;
    logic [33:0]                  pp;
    logic [PROD_W-1:0]            pp_sh;
    logic [33:0]                  rem_sh;
    logic                         ge;
    logic [33:0]                  rem_sub;
    logic [PROD_W-1:0]            quo_full;

    always_comb
    begin
        pa = step_reg[0] ? a_reg[33:17] : a_reg[16:0];
        pb = step_reg[1] ? b_reg[33:17] : b_reg[16:0];
        pp = pa * pb;
        case (step_reg)
            2'd0:    pp_sh = PROD_W'(pp);
            2'd1:    pp_sh = PROD_W'(pp) << 17;
            2'd2:    pp_sh = PROD_W'(pp) << 17;
            default: pp_sh = PROD_W'(pp) << 34;
        endcase
        rem_sh   = {rem_reg, acc_reg[PROD_W-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_sub  = rem_sh - {1'b0, den_reg};
        quo_full = {acc_reg[PROD_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            step_reg  <= '0;
            bit_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (req.start)
                    begin
                        a_reg     <= {1'b0, req.mul_a};
                        b_reg     <= {1'b0, req.mul_b};
                        den_reg   <= req.den;
                        acc_reg   <= '0;
                        step_reg  <= '0;
                        phase_reg <= PH_MUL;
                    end
                end
                PH_MUL:
                begin
                    // accumulate one partial product
                    acc_reg  <= acc_reg + pp_sh;
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        rem_reg   <= '0;
                        bit_reg   <= '0;
                        phase_reg <= PH_DIV;
                    end
                end
                PH_DIV:
                begin
                    // one restoring step: shift in a dividend bit, subtract if it fits
                    rem_reg <= ge ? rem_sub[32:0] : rem_sh[32:0];
                    acc_reg <= quo_full;
                    bit_reg <= bit_reg + 7'd1;
                    if (bit_reg == 7'(PROD_W - 1))
                    begin
                        if ((|quo_full[PROD_W-1:35]) || (quo_full[34] && (|quo_full[33:0])))
                            quo_reg <= {1'b1, 34'd0};
                        else
                            quo_reg <= quo_full[34:0];
                        done_reg  <= 1'b1;
                        phase_reg <= PH_IDLE;
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

@@ rtl/core/keyframe_curve_interpolator_unit.sv @@
// ============================================================================
// keyframe_curve_interpolator_unit: sorted keyframe table with interpolation
// Clears, inserts, removes and evaluates keyframes held in one on-chip memory.
// ============================================================================
// Steps per request: clear empties the table; add shifts each keyframe with a
//   larger time up one place, then writes the new one; remove moves each later
//   keyframe down one place; evaluate holds past the end, else does a binary
//   search with one table read per step, then the muldiv multiply and divide.
// Throughput: one request at a time; the next request is taken the cycle after
//   the response is loaded, which waits while the previous one is unread.
// Reset: table empty, end_margin 1; memory contents are not cleared.
// ============================================================================
module keyframe_curve_interpolator_unit
#(
    parameter int unsigned MAX_KEYS = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [kfci_pkg::MARGIN_W-1:0]     cfg_wr_data,
    kfci_in_if.sink                           req,
    kfci_out_if.source                        rsp
);

    localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int unsigned CW = $clog2(MAX_KEYS + 1);
    localparam int unsigned XW = (CW > kfci_pkg::COUNT_W) ? CW : kfci_pkg::COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_ADD_CMP, S_ADD_PUT, S_RM_WR, S_EV_ONE, S_EV_END,
        S_BS_CMP, S_LD_LO, S_LD_HI, S_WAIT, S_FIN
    } state_t;

    // Keyframe memory: {time, value} per entry, one write and one read port
    logic [63:0]            mem [MAX_KEYS];
    logic [63:0]            rd_data_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [63:0]            mem_wdata;
    logic [AW-1:0]          mem_raddr;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [15:0]            margin_reg;
    logic [1:0]             mode_reg, mode_next;
    logic signed [31:0]     kt_reg, kt_next;
    logic [31:0]            kv_reg, kv_next;
    logic [5:0]             idx_reg, idx_next;
    logic signed [31:0]     q_reg, q_next;
    logic [CW-1:0]          i_reg, i_next;
    logic [AW-1:0]          lo_reg, lo_next;
    logic [AW-1:0]          hi_reg, hi_next;
    logic [AW-1:0]          mid_reg, mid_next;
    logic signed [31:0]     t0_reg, t0_next;
    logic signed [31:0]     v0_reg, v0_next;
    logic                   neg_reg, neg_next;
    logic [31:0]            res_reg, res_next;
    logic [1:0]             st_reg, st_next;
    logic                   ov_reg, ov_next;
    logic [31:0]            oval_reg, oval_next;
    logic [1:0]             ost_reg, ost_next;
    logic [6:0]             ocnt_reg, ocnt_next;

    kfci_pkg::arith_req_t   ar_req;
    kfci_pkg::arith_rsp_t   ar_rsp;

    logic signed [31:0]     t_rd;
    logic signed [31:0]     v_rd;
    logic [XW-1:0]          cnt_x;
    logic [XW-1:0]          idx_x;
    logic [AW:0]            lohi_sum;
    logic signed [32:0]     end_time;
    logic signed [32:0]     dv;
    logic signed [32:0]     dq;
    logic [32:0]            den;
    logic [AW-1:0]          bs_lo, bs_hi;
    logic [AW:0]            bs_sum;
    logic signed [36:0]     step_s;
    logic signed [36:0]     sum_s;
    logic                   rsp_load;

    kfci_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ar_req),
        .rsp   (ar_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    assign t_rd  = rd_data_reg[63:32];
    assign v_rd  = rd_data_reg[31:0];
    assign cnt_x = XW'(count_reg);
    assign idx_x = XW'(idx_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        mode_next  = mode_reg;
        kt_next    = kt_reg;
        kv_next    = kv_reg;
        idx_next   = idx_reg;
        q_next     = q_reg;
        i_next     = i_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        t0_next    = t0_reg;
        v0_next    = v0_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        ov_next    = ov_reg;
        oval_next  = oval_reg;
        ost_next   = ost_reg;
        ocnt_next  = ocnt_reg;

        mem_we     = 1'b0;
        mem_waddr  = i_reg[AW-1:0];
        mem_wdata  = rd_data_reg;
        mem_raddr  = '0;
        rsp_load   = 1'b0;

        ar_req.start = 1'b0;
        dv  = $signed({v_rd[31], v_rd}) - $signed({v0_reg[31], v0_reg});
        dq  = $signed({q_reg[31], q_reg}) - $signed({t0_reg[31], t0_reg});
        den = 33'($signed({t_rd[31], t_rd}) - $signed({t0_reg[31], t0_reg}));
        ar_req.mul_a = dv[32] ? 33'(-dv) : 33'(dv);
        ar_req.mul_b = dq[32] ? 33'(-dq) : 33'(dq);
        ar_req.den   = den;

        end_time = $signed({t_rd[31], t_rd}) + $signed({17'd0, margin_reg});
        lohi_sum = (AW+1)'(count_reg - CW'(1));
        bs_lo    = lo_reg;
        bs_hi    = hi_reg;
        bs_sum   = '0;

        step_s = neg_reg ? -$signed({2'b00, ar_rsp.quo}) : $signed({2'b00, ar_rsp.quo});
        sum_s  = $signed({{5{v0_reg[31]}}, v0_reg}) + step_s;

        // drop the response once the sink takes it
        if (ov_reg && rsp.ready)
            ov_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next  = req.mode;
                    kt_next    = req.key_time;
                    kv_next    = req.key_value;
                    idx_next   = req.key_index;
                    q_next     = req.query_time;
                    res_next   = '0;
                    st_next    = kfci_pkg::STATUS_OK;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (mode_reg)
                    kfci_pkg::MODE_CLEAR:
                    begin
                        count_next = '0;
                        state_next = S_FIN;
                    end
                    kfci_pkg::MODE_ADD:
                    begin
                        i_next = count_reg;
                        if (count_reg == CW'(MAX_KEYS))
                        begin
                            st_next    = kfci_pkg::STATUS_BAD;
                            state_next = S_FIN;
                        end
                        else if (count_reg == '0)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            mem_wdata  = {kt_reg, kv_reg};
                            count_next = CW'(1);
                            state_next = S_FIN;
                        end
                        else
                        begin
                            mem_raddr  = AW'(count_reg - CW'(1));
                            state_next = S_ADD_CMP;
                        end
                    end
                    kfci_pkg::MODE_REMOVE:
                    begin
                        i_next = idx_x[CW-1:0];
                        if (idx_x >= cnt_x)
                        begin
                            st_next    = kfci_pkg::STATUS_BAD;
                            state_next = S_FIN;
                        end
                        else if (idx_x + XW'(1) < cnt_x)
                        begin
                            mem_raddr  = AW'(idx_x + XW'(1));
                            state_next = S_RM_WR;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = S_FIN;
                        end
                    end
                    default:
                    begin
                        if (count_reg == '0)
                        begin
                            st_next    = kfci_pkg::STATUS_EMPTY;
                            state_next = S_FIN;
                        end
                        else if (count_reg == CW'(1))
                        begin
                            mem_raddr  = '0;
                            state_next = S_EV_ONE;
                        end
                        else
                        begin
                            mem_raddr  = AW'(count_reg - CW'(1));
                            state_next = S_EV_END;
                        end
                    end
                endcase
            end
            S_ADD_CMP:
            begin
                // shift the larger keyframe up one place, or insert here
                mem_we = 1'b1;
                if (t_rd > kt_reg)
                begin
                    mem_wdata = rd_data_reg;
                    i_next    = i_reg - CW'(1);
                    if (i_reg == CW'(1))
                        state_next = S_ADD_PUT;
                    else
                        mem_raddr = AW'(i_reg - CW'(2));
                end
                else
                begin
                    mem_wdata  = {kt_reg, kv_reg};
                    count_next = count_reg + CW'(1);
                    state_next = S_FIN;
                end
            end
            S_ADD_PUT:
            begin
                mem_we     = 1'b1;
                mem_wdata  = {kt_reg, kv_reg};
                count_next = count_reg + CW'(1);
                state_next = S_FIN;
            end
            S_RM_WR:
            begin
                // move the next keyframe down one place
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg;
                i_next    = i_reg + CW'(1);
                if ((XW'(i_reg) + XW'(2)) < cnt_x)
                    mem_raddr = AW'(i_reg + CW'(2));
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_FIN;
                end
            end
            S_EV_ONE:
            begin
                res_next   = v_rd;
                st_next    = kfci_pkg::STATUS_HELD;
                state_next = S_FIN;
            end
            S_EV_END:
            begin
                if ($signed({q_reg[31], q_reg}) >= end_time)
                begin
                    res_next   = v_rd;
                    st_next    = kfci_pkg::STATUS_HELD;
                    state_next = S_FIN;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = AW'(count_reg - CW'(1));
                    mid_next   = lohi_sum[AW:1];
                    mem_raddr  = lohi_sum[AW:1];
                    state_next = S_BS_CMP;
                end
            end
            S_BS_CMP:
            begin
                if (t_rd > q_reg)
                    bs_hi = mid_reg;
                else
                    bs_lo = mid_reg;
                bs_sum  = (AW+1)'(bs_lo) + (AW+1)'(bs_hi);
                lo_next = bs_lo;
                hi_next = bs_hi;
                if (((AW+1)'(bs_lo) + (AW+1)'(1)) < (AW+1)'(bs_hi))
                begin
                    mid_next  = bs_sum[AW:1];
                    mem_raddr = bs_sum[AW:1];
                end
                else
                begin
                    mem_raddr  = bs_lo;
                    state_next = S_LD_LO;
                end
            end
            S_LD_LO:
            begin
                t0_next    = t_rd;
                v0_next    = v_rd;
                mem_raddr  = hi_reg;
                state_next = S_LD_HI;
            end
            S_LD_HI:
            begin
                if (t_rd <= t0_reg)
                begin
                    res_next   = v0_reg;
                    st_next    = kfci_pkg::STATUS_HELD;
                    state_next = S_FIN;
                end
                else
                begin
                    ar_req.start = 1'b1;
                    neg_next     = dv[32] != dq[32];
                    state_next   = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (ar_rsp.done)
                begin
                    if (sum_s > 37'sd2147483647)
                        res_next = 32'h7FFF_FFFF;
                    else if (sum_s < -37'sd2147483648)
                        res_next = 32'h8000_0000;
                    else
                        res_next = sum_s[31:0];
                    st_next    = kfci_pkg::STATUS_OK;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!ov_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    ov_next    = 1'b1;
                    oval_next  = res_reg;
                    ost_next   = st_reg;
                    ocnt_next  = cnt_x[kfci_pkg::COUNT_W-1:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            margin_reg <= 16'd1;
            ov_reg     <= 1'b0;
            mode_reg   <= '0;
            kt_reg     <= '0;
            kv_reg     <= '0;
            idx_reg    <= '0;
            q_reg      <= '0;
            i_reg      <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            mid_reg    <= '0;
            t0_reg     <= '0;
            v0_reg     <= '0;
            neg_reg    <= 1'b0;
            res_reg    <= '0;
            st_reg     <= '0;
            oval_reg   <= '0;
            ost_reg    <= '0;
            ocnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en)
                margin_reg <= cfg_wr_data;
            ov_reg    <= ov_next;
            mode_reg  <= mode_next;
            kt_reg    <= kt_next;
            kv_reg    <= kv_next;
            idx_reg   <= idx_next;
            q_reg     <= q_next;
            i_reg     <= i_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            mid_reg   <= mid_next;
            t0_reg    <= t0_next;
            v0_reg    <= v0_next;
            neg_reg   <= neg_next;
            res_reg   <= res_next;
            st_reg    <= st_next;
            oval_reg  <= oval_next;
            ost_reg   <= ost_next;
            ocnt_reg  <= ocnt_next;
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = ov_reg;
    assign rsp.curve_value = oval_reg;
    assign rsp.status      = ost_reg;
    assign rsp.key_count   = ocnt_reg;

    // Table never holds more keyframes than it has room for
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_KEYS))
        else $error("keyframe count exceeds table depth");

    // The memory is written only while a request is in progress
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_FIN) |-> !mem_we)
        else $error("keyframe memory written outside a request");

    // The divide result is only expected while evaluation waits for it
    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ar_rsp.done |-> state_reg == S_WAIT)
        else $error("divide result arrived outside evaluation");

    // A cleared table reports zero keyframes
    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && mode_reg == kfci_pkg::MODE_CLEAR) |=> rsp.key_count == '0)
        else $error("clear did not empty the table");

endmodule
